@@ rtl/mtsg_pkg.sv @@
package mtsg_pkg;

    localparam int NUM_TONES = 4;
    localparam int RATE_BITS = 20;
    localparam int TONE_BITS = $clog2(NUM_TONES);

    localparam logic [RATE_BITS-1:0] RATE_RST = RATE_BITS'(48000);
    localparam logic [31:0]          COUNT_RST = 32'd480000;
    localparam logic [63:0]          Q30_ONE = 64'sd1073741824;

    typedef enum logic [2:0] {
        REG_RATE  = 3'd0,
        REG_TONES = 3'd1,
        REG_WIDTH = 3'd2,
        REG_COUNT = 3'd3,
        REG_FREQ0 = 3'd4,
        REG_FREQ1 = 3'd5,
        REG_FREQ2 = 3'd6,
        REG_FREQ3 = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_PH,
        ST_DIV,
        ST_X2,
        ST_HORNER,
        ST_FINAL,
        ST_ACCUM,
        ST_AVG,
        ST_SCALE,
        ST_UPD_A,
        ST_UPD_B,
        ST_OUT
    } state_t;

    // Q30 coefficients of sin(pi/2*x), highest index first in Horner order
    function automatic logic signed [31:0] sine_coef(input logic [2:0] k);
        logic signed [31:0] c;
        case (k)
            3'd0:    c = 32'sd1686629713;
            3'd1:    c = -32'sd693598668;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = -32'sd5026995;
            3'd4:    c = 32'sd172272;
            3'd5:    c = -32'sd3864;
            3'd6:    c = 32'sd61;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/mtsg_if.sv @@
interface mtsg_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface mtsg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        last_of_run;
    modport source (output valid, output sample, output last_of_run, input ready);
    modport sink   (input valid, input sample, input last_of_run, output ready);
endinterface

@@ rtl/mtsg_divider.sv @@
// Restoring divider, one quotient bit per cycle. Unsigned 64 / 32.
module mtsg_divider
    import mtsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quo_reg[63]};
        done      = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_next;
    assign remainder = rem_next[31:0];
endmodule

@@ rtl/mtsg_mulq30.sv @@
// Registered signed multiply with truncating divide by 2^30.
module mtsg_mulq30
    import mtsg_pkg::*;
(
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [31:0] b,
    output logic signed [33:0] p
);
    logic signed [65:0] prod_reg;
    logic signed [65:0] adj;

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(a) * 66'(b);
    end

    always_comb
    begin
        adj = prod_reg;
        if (prod_reg < 0)
            adj = prod_reg + 66'sd1073741823;
    end

    assign p = 34'(adj >>> 30);
endmodule

@@ rtl/multi_tone_sine_generator_top.sv @@
// Channel   Dir  Payload
// in_ch     in   restart
// out_ch    out  sample[31:0] signed, last_of_run
// cfg       in   cfg_we, cfg_index[2:0], cfg_data[31:0]
//
// Each sample runs 64-bit bit-serial divides: per active tone a phase
// reduction and a turn fraction, then the average, then for all four
// phases a reduction of the phase and of the frequency and an add
// (skipped on the last sample of a run). One registered multiplier does
// Horner and scaling. Reset clears state; not ready while a sample is in
// work or waiting on out_ch.
module multi_tone_sine_generator_top
    import mtsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mtsg_in_if.sink     in_ch,
    mtsg_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [RATE_BITS-1:0] rate_reg;
    logic [2:0]           tones_reg;
    logic                 wmode_reg;
    logic [31:0]          count_reg;
    logic [19:0]          freq_reg [NUM_TONES];
    logic [RATE_BITS-1:0] phase_reg [NUM_TONES];
    logic [31:0]          index_reg;

    state_t state_reg, state_next;
    logic [TONE_BITS:0]   tone_reg, tone_next;
    logic [2:0]           coef_reg, coef_next;
    logic                 wait_reg, wait_next;
    logic                 sub_reg, sub_next;
    logic signed [33:0]   x_reg, x_next, x2_reg, x2_next, p_reg, p_next;
    logic [1:0]           quad_reg, quad_next;
    logic signed [33:0]   sum_reg, sum_next;
    logic [RATE_BITS-1:0] ph_reg, ph_next;
    logic signed [31:0]   sample_reg, sample_next;
    logic                 last_reg, last_next;
    logic                 valid_reg, valid_next;
    logic                 restart_reg, restart_next;

    logic        div_start, div_done;
    logic [63:0] div_a, div_q;
    logic [31:0] div_b, div_r;
    logic signed [33:0] mul_a, mul_p;
    logic signed [31:0] mul_b;

    logic [31:0]        rate_eff;
    logic [TONE_BITS:0] ntones;
    logic signed [33:0] sabs;
    logic               is_last;

    mtsg_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    mtsg_mulq30 u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    assign rate_eff = (rate_reg == '0) ? 32'd1 : 32'(rate_reg);
    always_comb
    begin
        if (tones_reg == 3'd0)
            ntones = (TONE_BITS+1)'(1);
        else if (32'(tones_reg) > NUM_TONES)
            ntones = (TONE_BITS+1)'(NUM_TONES);
        else
            ntones = tones_reg[TONE_BITS:0];
    end
    // a restart item counts from index zero
    assign is_last = ((restart_reg ? 32'd0 : index_reg) + 32'd1) == count_reg;

    assign in_ch.ready        = (state_reg == ST_IDLE) && !valid_reg;
    assign out_ch.valid       = valid_reg;
    assign out_ch.sample      = sample_reg;
    assign out_ch.last_of_run = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        tone_next    = tone_reg;
        coef_next    = coef_reg;
        wait_next    = 1'b0;
        sub_next     = sub_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        p_next       = p_reg;
        quad_next    = quad_reg;
        sum_next     = sum_reg;
        ph_next      = ph_reg;
        sample_next  = sample_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        restart_next = restart_reg;
        div_start    = 1'b0;
        div_a        = '0;
        div_b        = rate_eff;
        mul_a        = x_reg;
        mul_b        = 32'(x_reg);
        sabs         = '0;
        if (valid_reg && out_ch.ready)
            valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    restart_next = in_ch.restart;
                    tone_next    = '0;
                    sum_next     = '0;
                    state_next   = ST_MOD_PH;
                    wait_next    = 1'b1;
                end
            end
            ST_MOD_PH:
            begin
                div_a = restart_reg ? 64'd0 : 64'(phase_reg[tone_reg[TONE_BITS-1:0]]);
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    ph_next    = RATE_BITS'(div_r);
                    state_next = ST_DIV;
                    wait_next  = 1'b1;
                end
            end
            ST_DIV:
            begin
                div_a = {12'd0, ph_reg, 32'd0};
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    quad_next = div_q[31:30];
                    x_next    = div_q[30] ? (34'sd1073741824 - 34'(div_q[29:0]))
                                          : 34'(div_q[29:0]);
                    state_next = ST_X2;
                    wait_next  = 1'b1;
                end
            end
            ST_X2:
            begin
                if (!wait_reg)
                begin
                    x2_next    = mul_p;
                    p_next     = 34'(sine_coef(3'd6));
                    coef_next  = 3'd5;
                    state_next = ST_HORNER;
                    wait_next  = 1'b1;
                end
            end
            ST_HORNER:
            begin
                mul_a = p_reg;
                mul_b = 32'(x2_reg);
                if (!wait_reg)
                begin
                    p_next    = 34'(sine_coef(coef_reg)) + mul_p;
                    wait_next = 1'b1;
                    if (coef_reg == 3'd0)
                        state_next = ST_FINAL;
                    else
                        coef_next = coef_reg - 3'd1;
                end
            end
            ST_FINAL:
            begin
                mul_a = p_reg;
                mul_b = 32'(x_reg);
                if (!wait_reg)
                begin
                    p_next     = mul_p;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                sabs = p_reg;
                if (p_reg < 0)
                    sabs = '0;
                if (p_reg > 34'sd1073741824)
                    sabs = 34'sd1073741824;
                sum_next = quad_reg[1] ? (sum_reg - sabs) : (sum_reg + sabs);
                if (tone_reg + 1'b1 == ntones)
                begin
                    state_next = ST_AVG;
                    wait_next  = 1'b1;
                end
                else
                begin
                    tone_next  = tone_reg + 1'b1;
                    state_next = ST_MOD_PH;
                    wait_next  = 1'b1;
                end
            end
            ST_AVG:
            begin
                div_a = sum_reg[33] ? 64'(-sum_reg) : 64'(sum_reg);
                div_b = 32'(ntones);
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    x_next     = sum_reg[33] ? -34'(div_q[31:0]) : 34'(div_q[31:0]);
                    state_next = ST_SCALE;
                    wait_next  = 1'b1;
                end
            end
            ST_SCALE:
            begin
                mul_a = x_reg;
                mul_b = wmode_reg ? 32'sd2147483647 : 32'sd32767;
                if (!wait_reg)
                begin
                    sample_next = 32'(mul_p);
                    last_next   = is_last;
                    tone_next   = '0;
                    state_next  = is_last ? ST_OUT : ST_UPD_A;
                    wait_next   = 1'b1;
                end
            end
            ST_UPD_A:
            begin
                div_a = restart_reg ? 64'd0 : 64'(phase_reg[tone_reg[TONE_BITS-1:0]]);
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    ph_next    = RATE_BITS'(div_r);
                    state_next = ST_UPD_B;
                    wait_next  = 1'b1;
                    sub_next   = 1'b0;
                end
            end
            ST_UPD_B:
            begin
                // freq mod rate, then (ph + f) mod rate by a conditional subtract
                div_a = sub_reg ? 64'(ph_reg) : 64'(freq_reg[tone_reg[TONE_BITS-1:0]]);
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    if (!sub_reg)
                    begin
                        ph_next   = RATE_BITS'((33'(ph_reg) + 33'(div_r)) >= 33'(rate_eff)
                                    ? (33'(ph_reg) + 33'(div_r) - 33'(rate_eff))
                                    : (33'(ph_reg) + 33'(div_r)));
                        state_next = ST_OUT;
                        if (tone_reg + 1'b1 != (TONE_BITS+1)'(NUM_TONES))
                        begin
                            tone_next  = tone_reg + 1'b1;
                            state_next = ST_UPD_A;
                            wait_next  = 1'b1;
                        end
                        sub_next = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!valid_reg)
                begin
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= 1'b0;
            wait_reg    <= 1'b0;
            rate_reg    <= RATE_RST;
            tones_reg   <= 3'd4;
            wmode_reg   <= 1'b1;
            count_reg   <= COUNT_RST;
            index_reg   <= '0;
            restart_reg <= 1'b0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                freq_reg[i]  <= '0;
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            wait_reg    <= wait_next;
            restart_reg <= restart_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index)) inside
                    REG_RATE:  rate_reg  <= cfg_data[RATE_BITS-1:0];
                    REG_TONES: tones_reg <= cfg_data[2:0];
                    REG_WIDTH: wmode_reg <= cfg_data[0];
                    REG_COUNT: count_reg <= cfg_data;
                    REG_FREQ0, REG_FREQ1, REG_FREQ2, REG_FREQ3:
                    begin
                        if (32'(cfg_index) - 32'd4 < NUM_TONES)
                            freq_reg[TONE_BITS'(cfg_index - 3'd4)] <= cfg_data[19:0];
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_SCALE && !wait_reg)
            begin
                if (is_last)
                begin
                    index_reg <= '0;
                    for (int i = 0; i < NUM_TONES; i++)
                        phase_reg[i] <= '0;
                end
                else
                    index_reg <= (restart_reg ? 32'd0 : index_reg) + 32'd1;
            end
            if (state_reg == ST_UPD_B && !wait_reg && div_done && !sub_reg)
                phase_reg[tone_reg[TONE_BITS-1:0]] <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tone_reg   <= tone_next;
        coef_reg   <= coef_next;
        sub_reg    <= sub_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        p_reg      <= p_next;
        quad_reg   <= quad_next;
        sum_reg    <= sum_next;
        ph_reg     <= ph_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == ST_MOD_PH)
        else $error("accept did not start work");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("accepted with result pending");
endmodule
